// ----- rtl/assert_macros.svh -----
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is asserted
`define PE_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// clocked property that also holds through reset
`define PE_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// ----- rtl/pe_pkg.sv -----
// types, constants and helpers of the polynomial and derivative evaluator
package pe_pkg;

  // polynomial size and fixed-point format
  localparam int NUM_COEFFS = 6;
  localparam int FRAC_BITS  = 16;
  localparam int NUM_REGS   = 6;
  localparam int NUM_LANES  = 4;

  // field widths
  localparam int PT_W      = 32;
  localparam int CF_W      = 32;
  localparam int OUT_W     = 48;
  localparam int DCOEF_W   = 40;
  localparam int CFG_IDX_W = $clog2(NUM_REGS);

  // split multiplier widths
  localparam int HALF_W = OUT_W / 2;
  localparam int PP_W   = HALF_W + PT_W;
  localparam int FULL_W = OUT_W + PT_W;

  // pipeline shape
  localparam int STAGES_PER_CELL = 4;
  localparam int PIPE_DEPTH      = STAGES_PER_CELL * NUM_COEFFS;

  typedef logic signed [PT_W-1:0]    point_t;
  typedef logic signed [OUT_W-1:0]   acc_t;
  typedef logic signed [DCOEF_W-1:0] dcoef_t;
  typedef acc_t   [NUM_LANES-1:0]    acc_vec_t;
  typedef dcoef_t [NUM_LANES-1:0]    dcoef_vec_t;
  typedef logic   [NUM_LANES-1:0]    lane_mask_t;

  // per-stage load strobes from a cell to its lanes
  typedef struct packed {
    logic ld_a;
    logic ld_b;
    logic ld_c;
    logic ld_d;
  } pe_ld_t;

  // saturation limits and rounding bias
  localparam acc_t ACC_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic [FULL_W-1:0] MAG_NEG_LIM = FULL_W'(1) << (OUT_W - 1);
  localparam logic [FULL_W-1:0] MAG_POS_LIM = MAG_NEG_LIM - FULL_W'(1);
  localparam logic [FULL_W-1:0] RND_BIAS    = FULL_W'(1) << (FRAC_BITS - 1);

  // falling factorial i*(i-1)*..*(i-k+1) of the k-th derivative
  function automatic int factor(input int i, input int k);
    int f;
    f = 1;
    for (int j = 0; j < k; j++) begin
      f = f * (i - j);
    end
    return f;
  endfunction

endpackage

// ----- rtl/pe_in_if.sv -----
// request channel carrying the evaluation point
interface pe_in_if;
  import pe_pkg::*;

  logic   valid;
  logic   ready;
  point_t point;

  modport source (output valid, point, input ready);
  modport sink   (input valid, point, output ready);
  modport mon    (input valid, ready, point);
endinterface

// ----- rtl/pe_out_if.sv -----
// result channel carrying value, derivatives and saturation flag
interface pe_out_if;
  import pe_pkg::*;

  logic valid;
  logic ready;
  acc_t value;
  acc_t slope;
  acc_t curvature;
  acc_t jerk;
  logic saturated;

  modport source (output valid, value, slope, curvature, jerk, saturated, input ready);
  modport sink   (input valid, value, slope, curvature, jerk, saturated, output ready);
  modport mon    (input valid, ready, value, slope, curvature, jerk, saturated);
endinterface

// ----- rtl/pe_lane.sv -----
// one derivative lane of a cell: acc * point, round, clip, add coefficient, clip
module pe_lane (
  input  logic                      clk,
  input  pe_pkg::pe_ld_t            ld,
  input  logic                      en,
  input  pe_pkg::acc_t              acc_in,
  input  logic                      x_neg,
  input  logic [pe_pkg::PT_W-1:0]   mx_in,
  input  logic [pe_pkg::PT_W-1:0]   mx_a,
  input  pe_pkg::dcoef_t            dcoef,
  output pe_pkg::acc_t              acc_out,
  output logic                      sat_out
);
  import pe_pkg::*;

  logic [OUT_W-1:0]      acc_u;
  logic [OUT_W-1:0]      ma;
  logic [PP_W-1:0]       plo_nxt;
  logic [PP_W-1:0]       phi_nxt;
  logic [FULL_W-1:0]     full;
  logic [FULL_W-1:0]     rmag;
  acc_t                  mres_nxt;
  logic                  msat_nxt;
  logic signed [OUT_W:0] sum;
  logic                  asat;
  acc_t                  add_val;
  acc_t                  acc_d_nxt;
  logic                  sat_d_nxt;

  logic                  neg_a_r, neg_b_r;
  logic [HALF_W-1:0]     mahi_a_r;
  logic [PP_W-1:0]       plo_a_r, plo_b_r, phi_b_r;
  acc_t                  acc_a_r, acc_b_r, acc_c_r, acc_d_r;
  acc_t                  mres_c_r;
  logic                  msat_c_r;
  logic                  sat_d_r;

  // stage a: magnitude of the accumulator, low partial product
  always_comb begin
    acc_u   = acc_in;
    ma      = acc_in[OUT_W-1] ? (~acc_u + 1'b1) : acc_u;
    plo_nxt = PP_W'(ma[HALF_W-1:0]) * PP_W'(mx_in);
  end

  always_ff @(posedge clk) begin
    if (ld.ld_a) begin
      neg_a_r  <= acc_in[OUT_W-1] ^ x_neg;
      mahi_a_r <= ma[OUT_W-1:HALF_W];
      plo_a_r  <= plo_nxt;
      acc_a_r  <= acc_in;
    end
  end

  // stage b: high partial product
  assign phi_nxt = PP_W'(mahi_a_r) * PP_W'(mx_a);

  always_ff @(posedge clk) begin
    if (ld.ld_b) begin
      neg_b_r <= neg_a_r;
      plo_b_r <= plo_a_r;
      phi_b_r <= phi_nxt;
      acc_b_r <= acc_a_r;
    end
  end

  // stage c: join partial products, round half away from zero, apply sign, clip
  always_comb begin
    full     = (FULL_W'(phi_b_r) << HALF_W) + FULL_W'(plo_b_r) + RND_BIAS;
    rmag     = full >> FRAC_BITS;
    msat_nxt = 1'b0;
    if (neg_b_r) begin
      if (rmag > MAG_NEG_LIM) begin
        msat_nxt = 1'b1;
        mres_nxt = ACC_MIN;
      end else begin
        mres_nxt = acc_t'(~rmag[OUT_W-1:0] + 1'b1);
      end
    end else begin
      if (rmag > MAG_POS_LIM) begin
        msat_nxt = 1'b1;
        mres_nxt = ACC_MAX;
      end else begin
        mres_nxt = acc_t'(rmag[OUT_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld_c) begin
      mres_c_r <= mres_nxt;
      msat_c_r <= msat_nxt;
      acc_c_r  <= acc_b_r;
    end
  end

  // stage d: add derivative coefficient and clip, idle lanes pass through
  always_comb begin
    sum       = (OUT_W+1)'(mres_c_r) + (OUT_W+1)'(dcoef);
    asat      = sum[OUT_W] ^ sum[OUT_W-1];
    add_val   = asat ? (sum[OUT_W] ? ACC_MIN : ACC_MAX) : sum[OUT_W-1:0];
    acc_d_nxt = en ? add_val : acc_c_r;
    sat_d_nxt = en & (msat_c_r | asat);
  end

  always_ff @(posedge clk) begin
    if (ld.ld_d) begin
      acc_d_r <= acc_d_nxt;
      sat_d_r <= sat_d_nxt;
    end
  end

  assign acc_out = acc_d_r;
  assign sat_out = sat_d_r;

endmodule

// ----- rtl/pe_cell.sv -----
// one horner step for all derivative lanes, four pipeline stages with flow control
module pe_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pe_pkg::point_t     in_x,
  input  pe_pkg::acc_vec_t   in_acc,
  input  logic               in_sat,
  input  pe_pkg::lane_mask_t lane_en,
  input  pe_pkg::dcoef_vec_t dcoef,
  output logic               out_valid,
  input  logic               out_ready,
  output pe_pkg::point_t     out_x,
  output pe_pkg::acc_vec_t   out_acc,
  output logic               out_sat
);
  import pe_pkg::*;

  logic                 v_a_r, v_b_r, v_c_r, v_d_r;
  logic                 rdy_a, rdy_b, rdy_c, rdy_d;
  pe_ld_t               ld;
  logic                 x_neg;
  logic [PT_W-1:0]      x_u;
  logic [PT_W-1:0]      mx_nxt;
  logic [PT_W-1:0]      mx_a_r;
  point_t               x_a_r, x_b_r, x_c_r, x_d_r;
  logic                 sat_a_r, sat_b_r, sat_c_r, sat_d_r;
  acc_t                 lane_acc [NUM_LANES];
  logic [NUM_LANES-1:0] lane_sat;

  // a stage takes a new request when it is empty or its content moves on
  always_comb begin
    rdy_d    = !v_d_r || out_ready;
    rdy_c    = !v_c_r || rdy_d;
    rdy_b    = !v_b_r || rdy_c;
    rdy_a    = !v_a_r || rdy_b;
    ld.ld_a  = rdy_a & in_valid;
    ld.ld_b  = rdy_b & v_a_r;
    ld.ld_c  = rdy_c & v_b_r;
    ld.ld_d  = rdy_d & v_c_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
    end else begin
      if (rdy_a) v_a_r <= in_valid;
      if (rdy_b) v_b_r <= v_a_r;
      if (rdy_c) v_c_r <= v_b_r;
      if (rdy_d) v_d_r <= v_c_r;
    end
  end

  // magnitude and sign of the point, shared by all lanes
  always_comb begin
    x_u    = in_x;
    x_neg  = in_x[PT_W-1];
    mx_nxt = x_neg ? (~x_u + 1'b1) : x_u;
  end

  // point and running saturation flag travel alongside the lanes
  always_ff @(posedge clk) begin
    if (ld.ld_a) begin
      x_a_r   <= in_x;
      mx_a_r  <= mx_nxt;
      sat_a_r <= in_sat;
    end
    if (ld.ld_b) begin
      x_b_r   <= x_a_r;
      sat_b_r <= sat_a_r;
    end
    if (ld.ld_c) begin
      x_c_r   <= x_b_r;
      sat_c_r <= sat_b_r;
    end
    if (ld.ld_d) begin
      x_d_r   <= x_c_r;
      sat_d_r <= sat_c_r;
    end
  end

  // derivative lanes
  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    pe_lane u_lane (
      .clk     (clk),
      .ld      (ld),
      .en      (lane_en[k]),
      .acc_in  (in_acc[k]),
      .x_neg   (x_neg),
      .mx_in   (mx_nxt),
      .mx_a    (mx_a_r),
      .dcoef   (dcoef[k]),
      .acc_out (lane_acc[k]),
      .sat_out (lane_sat[k])
    );
  end

  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      out_acc[k] = lane_acc[k];
    end
  end

  assign in_ready  = rdy_a;
  assign out_valid = v_d_r;
  assign out_x     = x_d_r;
  assign out_sat   = sat_d_r | (|lane_sat);

endmodule

// ----- rtl/poly_eval_with_derivatives.sv -----
// Evaluates a polynomial of degree up to NUM_COEFFS-1 and its first three derivatives at one
// point per request, by Horner's rule in signed Q16.16 with results saturated to Q32.16. The
// coefficients are written through the cfg port (index i holds the coefficient of point^i);
// on each write the three scaled derivative coefficients are formed once and held. The datapath
// is a chain of NUM_COEFFS cells, one Horner step each, all four evaluations side by side; a
// cell runs through two partial-product multiplier stages, a round and clip stage and a
// coefficient add and clip stage, and takes one request every cycle unless the output stalls.
// Each stage holds its own request, so the chain keeps filling while a result waits at the
// output; in_ch.ready is high whenever out_ch.ready is high.
module poly_eval_with_derivatives (
  input  logic                         clk,
  input  logic                         rst_n,
  pe_in_if.sink                        in_ch,
  pe_out_if.source                     out_ch,
  input  logic                         cfg_we,
  input  logic [pe_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [pe_pkg::CF_W-1:0]      cfg_data
);
  import pe_pkg::*;

  dcoef_vec_t dcoef_r  [NUM_COEFFS];
  logic       ch_valid [NUM_COEFFS+1];
  logic       ch_ready [NUM_COEFFS+1];
  point_t     ch_x     [NUM_COEFFS+1];
  acc_vec_t   ch_acc   [NUM_COEFFS+1];
  logic       ch_sat   [NUM_COEFFS+1];

  // coefficient registers, held pre-scaled for each derivative order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEFFS; i++) begin
        dcoef_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_COEFFS; i++) begin
        if (cfg_we && (i < NUM_REGS) && (cfg_idx == CFG_IDX_W'(i))) begin
          for (int k = 0; k < NUM_LANES; k++) begin
            dcoef_r[i][k] <= DCOEF_W'(factor(i, k)) * DCOEF_W'($signed(cfg_data));
          end
        end
      end
    end
  end

  // head of the chain
  assign ch_valid[0] = in_ch.valid;
  assign in_ch.ready = ch_ready[0];
  assign ch_x[0]     = in_ch.point;
  assign ch_acc[0]   = '0;
  assign ch_sat[0]   = 1'b0;

  // cell j handles the term of degree NUM_COEFFS-1-j
  for (genvar j = 0; j < NUM_COEFFS; j++) begin : g_cell
    localparam int Deg = NUM_COEFFS - 1 - j;
    lane_mask_t lane_en;

    for (genvar k = 0; k < NUM_LANES; k++) begin : g_en
      assign lane_en[k] = (Deg >= k);
    end

    pe_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (ch_valid[j]),
      .in_ready  (ch_ready[j]),
      .in_x      (ch_x[j]),
      .in_acc    (ch_acc[j]),
      .in_sat    (ch_sat[j]),
      .lane_en   (lane_en),
      .dcoef     (dcoef_r[Deg]),
      .out_valid (ch_valid[j+1]),
      .out_ready (ch_ready[j+1]),
      .out_x     (ch_x[j+1]),
      .out_acc   (ch_acc[j+1]),
      .out_sat   (ch_sat[j+1])
    );
  end

  // tail of the chain
  assign out_ch.valid          = ch_valid[NUM_COEFFS];
  assign ch_ready[NUM_COEFFS]  = out_ch.ready;
  assign out_ch.value          = ch_acc[NUM_COEFFS][0];
  assign out_ch.slope          = ch_acc[NUM_COEFFS][1];
  assign out_ch.curvature      = ch_acc[NUM_COEFFS][2];
  assign out_ch.jerk           = ch_acc[NUM_COEFFS][3];
  assign out_ch.saturated      = ch_sat[NUM_COEFFS];

endmodule

// ----- rtl/pe_checker.sv -----
// port-level checks of the evaluator, bound to the top level
`include "assert_macros.svh"

module pe_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input pe_pkg::acc_t out_value,
  input pe_pkg::acc_t out_slope,
  input pe_pkg::acc_t out_curvature,
  input pe_pkg::acc_t out_jerk,
  input logic         out_saturated
);
  import pe_pkg::*;

  localparam int CNT_W = $clog2(PIPE_DEPTH + 2);

  logic                 in_acc;
  logic                 out_acc;
  logic [CNT_W-1:0]     cnt_r;
  logic [CNT_W-1:0]     cnt_nxt;
  logic [4*OUT_W:0]     out_pl;

  // whole result payload, for the hold check
  assign out_pl = {out_value, out_slope, out_curvature, out_jerk, out_saturated};

  // requests in flight
  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign cnt_nxt = cnt_r + CNT_W'(in_acc) - CNT_W'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // nothing left in the pipe once reset has been applied
  `PE_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

  // a waiting result keeps its value
  `PE_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_pl))

  // no result without a request behind it
  `PE_ASSERT(a_no_phantom, clk, rst_n, out_valid |-> cnt_r != '0)

  // never more requests inside than pipeline stages
  `PE_ASSERT(a_depth, clk, rst_n, cnt_r <= CNT_W'(PIPE_DEPTH))

  // a draining output never blocks the input
  `PE_ASSERT(a_ready_flow, clk, rst_n, out_ready |-> in_ready)

endmodule

bind poly_eval_with_derivatives pe_checker u_pe_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_value     (out_ch.value),
  .out_slope     (out_ch.slope),
  .out_curvature (out_ch.curvature),
  .out_jerk      (out_ch.jerk),
  .out_saturated (out_ch.saturated)
);

// ----- tb/tb.sv -----
// testbench for the polynomial and derivative evaluator: directed and random requests
module tb;
  import pe_pkg::*;

  typedef logic [NUM_REGS-1:0][CF_W-1:0] coeff_set_t;

  typedef struct packed {
    acc_t value;
    acc_t slope;
    acc_t curvature;
    acc_t jerk;
    logic saturated;
  } poly_eval_t;

  // register map: coefficient of point^i sits at index i
  localparam int REG_COEFF0  = 0;
  localparam int REG_TOP_IDX = (1 << CFG_IDX_W) - 1;

  // fixed-point limits used by the predictor
  localparam longint unsigned Q_TOP     = 64'd1 << (OUT_W - 1);
  localparam longint unsigned MUL_LIM   = 64'd1 << 62;
  localparam longint unsigned HALF_LSB  = 64'd1 << (FRAC_BITS - 1);
  localparam longint unsigned FRAC_MASK = (64'd1 << FRAC_BITS) - 1;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int RAND_SETS   = 4;
  localparam int SET_ITEMS   = 140;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CF_W-1:0]      cfg_data;
  logic                 hold_go;

  pe_in_if  in_ch ();
  pe_out_if out_ch ();

  poly_eval_with_derivatives dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  longint     coeff_q [NUM_COEFFS];
  poly_eval_t expected_evals [$];
  int         fail_count;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         stall_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // saturate a signed magnitude to the q32.16 result range
  function automatic longint clip_q32(input bit neg, input longint unsigned mag,
                                      inout bit sat);
    if (neg) begin
      if (mag > Q_TOP) begin
        sat = 1'b1;
        mag = Q_TOP;
      end
      return -$signed(mag);
    end
    if (mag > Q_TOP - 1) begin
      sat = 1'b1;
      mag = Q_TOP - 1;
    end
    return $signed(mag);
  endfunction

  // accumulator times point, rounded half away from zero on magnitudes
  function automatic longint mul_by_point(input longint acc, input longint x, inout bit sat);
    bit              neg;
    longint unsigned ma, mx, hi, lo, mag;
    neg = (acc < 0) != (x < 0);
    ma  = (acc < 0) ? -acc : acc;
    mx  = (x < 0) ? -x : x;
    hi  = ma >> FRAC_BITS;
    lo  = ma & FRAC_MASK;
    if (hi != 0 && mx > MUL_LIM / hi) begin
      mag = MUL_LIM;
    end else begin
      mag = hi * mx + ((lo * mx + HALF_LSB) >> FRAC_BITS);
    end
    if (mag == 0) begin
      return 0;
    end
    return clip_q32(neg, mag, sat);
  endfunction

  function automatic longint add_clipped(input longint a, input longint b, inout bit sat);
    longint sum;
    sum = a + b;
    if (sum < 0) begin
      return clip_q32(1'b1, -sum, sat);
    end
    return clip_q32(1'b0, sum, sat);
  endfunction

  // i*(i-1)*... over k terms, scaling for the k-th derivative
  function automatic longint falling_factor(input int i, input int k);
    longint f;
    f = 1;
    for (int j = 0; j < k; j++) begin
      f = f * (i - j);
    end
    return f;
  endfunction

  function automatic longint horner_deriv(input int k, input longint x, inout bit sat);
    longint acc;
    acc = 0;
    for (int i = NUM_COEFFS - 1; i >= k; i--) begin
      acc = mul_by_point(acc, x, sat);
      acc = add_clipped(acc, falling_factor(i, k) * coeff_q[i], sat);
    end
    return acc;
  endfunction

  function automatic poly_eval_t eval_poly_at(input point_t p);
    poly_eval_t r;
    bit         sat;
    longint     x;
    sat         = 1'b0;
    x           = p;
    r.value     = acc_t'(horner_deriv(0, x, sat));
    r.slope     = acc_t'(horner_deriv(1, x, sat));
    r.curvature = acc_t'(horner_deriv(2, x, sat));
    r.jerk      = acc_t'(horner_deriv(3, x, sat));
    r.saturated = sat;
    return r;
  endfunction

  // predict on every accepted request
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      expected_evals = {expected_evals, eval_poly_at(in_ch.point)};
    end
  end

  task automatic note_mismatch(input string field, input acc_t want, input acc_t got);
    if (fail_count < 100) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    end
    fail_count++;
  endtask

  // compare each result with the oldest prediction
  always @(posedge clk) begin
    poly_eval_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_evals.size() == 0) begin
        $display("%0t: result with no request outstanding, value %h", $time, out_ch.value);
        fail_count++;
      end else begin
        want = expected_evals.pop_front();
        if (out_ch.value !== want.value) begin
          note_mismatch("value", want.value, out_ch.value);
        end
        if (out_ch.slope !== want.slope) begin
          note_mismatch("slope", want.slope, out_ch.slope);
        end
        if (out_ch.curvature !== want.curvature) begin
          note_mismatch("curvature", want.curvature, out_ch.curvature);
        end
        if (out_ch.jerk !== want.jerk) begin
          note_mismatch("jerk", want.jerk, out_ch.jerk);
        end
        if (out_ch.saturated !== want.saturated) begin
          note_mismatch("saturated", acc_t'(want.saturated), acc_t'(out_ch.saturated));
        end
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // result side: random ready, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_go) begin
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // offer one point, idling at random first, and wait until it is taken
  task automatic send_point(input point_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.point <= p;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_evals.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [CF_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx[CFG_IDX_W-1:0];
    cfg_data <= data;
    if (idx < NUM_COEFFS) begin
      coeff_q[idx] = $signed(data);
    end
    @(posedge clk);
  endtask

  task automatic load_coeff_set(input coeff_set_t cs);
    wait_drained();
    for (int i = 0; i < NUM_REGS; i++) begin
      write_reg(REG_COEFF0 + i, cs[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] edge_word();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'h7FFF_FFFF;
      4: return 32'h8000_0000;
      5: return 32'h0001_0000;
      6: return 32'hFFFF_0000;
      default: return 32'h0000_8000;
    endcase
  endfunction

  // points: full range, within +-4.0, within +-256.0, and edge values
  function automatic point_t random_point();
    case ($urandom_range(3))
      0: return point_t'($urandom);
      1: return point_t'($urandom_range(32'h0008_0000)) - point_t'(32'h0004_0000);
      2: return point_t'($urandom_range(32'h0200_0000)) - point_t'(32'h0100_0000);
      default: return point_t'(edge_word());
    endcase
  endfunction

  // coefficient sets: all small, all full range, all edge values, or a mix
  function automatic coeff_set_t random_coeff_set();
    coeff_set_t cs;
    int         style;
    int         kind;
    style = $urandom_range(3);
    for (int i = 0; i < NUM_REGS; i++) begin
      kind = (style == 3) ? $urandom_range(2) : style;
      case (kind)
        0: cs[i] = $urandom_range(32'h0010_0000) - 32'h0008_0000;
        1: cs[i] = $urandom;
        default: cs[i] = edge_word();
      endcase
    end
    return cs;
  endfunction

  // coefficients straight out of reset are all zero
  task automatic test_reset_state();
    send_point(32'h0001_0000);
    send_point(32'h7FFF_FFFF);
    send_point(32'h8000_0000);
  endtask

  // every coefficient 1.0 against the edges of the point range
  task automatic test_unit_coeffs();
    load_coeff_set({NUM_REGS{32'h0001_0000}});
    send_point(32'h0000_0000);
    send_point(32'h0000_0001);
    send_point(32'hFFFF_FFFF);
    send_point(32'h0000_8000);
    send_point(32'hFFFF_8000);
    send_point(32'h0001_0000);
    send_point(32'hFFFF_0000);
    send_point(32'h0002_0000);
    send_point(32'h7FFF_FFFF);
    send_point(32'h8000_0000);
  endtask

  // largest and most negative coefficients: clipping of products and sums
  task automatic test_extreme_coeffs();
    load_coeff_set({NUM_REGS{32'h7FFF_FFFF}});
    send_point(32'h7FFF_FFFF);
    send_point(32'h8000_0000);
    send_point(32'h0000_0001);
    load_coeff_set({NUM_REGS{32'h8000_0000}});
    send_point(32'h7FFF_FFFF);
    send_point(32'hFFFF_FFFF);
    send_point(32'h0002_0000);
  endtask

  // half-lsb products must round away from zero on either sign
  task automatic test_rounding_ties();
    load_coeff_set({32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_0003, 32'h0000_0001});
    send_point(32'h0000_8000);
    send_point(32'hFFFF_8000);
  endtask

  // writes to indexes past the last coefficient change nothing
  task automatic test_unused_index();
    wait_drained();
    for (int i = NUM_REGS; i <= REG_TOP_IDX; i++) begin
      write_reg(i, $urandom);
    end
    cfg_we <= 1'b0;
    send_point(32'h0003_0000);
    send_point(32'hFFFD_0000);
  endtask

  // result side held off long enough for the pipeline to fill and stall
  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    load_coeff_set(random_coeff_set());
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    for (int n = 0; n < 60; n++) begin
      send_point(random_point());
    end
  endtask

  task automatic run_idle_phase(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    for (int s = 0; s < RAND_SETS; s++) begin
      load_coeff_set(random_coeff_set());
      for (int n = 0; n < SET_ITEMS; n++) begin
        if ($urandom_range(49) == 0) begin
          wait_drained();
        end
        send_point(random_point());
      end
    end
  endtask

  task automatic test_random_traffic();
    run_idle_phase(18, 51);
    run_idle_phase(51, 18);
    run_idle_phase(0, 0);
  endtask

  // sequence of tests
  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.point  <= '0;
    cfg_we       <= 1'b0;
    cfg_idx      <= '0;
    cfg_data     <= '0;
    hold_go      <= 1'b0;
    recv_idle_pct <= 0;
    send_idle_pct = 0;
    fail_count    = 0;
    for (int i = 0; i < NUM_COEFFS; i++) begin
      coeff_q[i] = 0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_unit_coeffs();
    test_extreme_coeffs();
    test_rounding_ties();
    test_unused_index();
    test_output_hold();
    test_random_traffic();

    wait_drained();
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
